### src/tqbls_pkg.sv
// Shared opcodes, status codes and register constants for the two-queue scheduler
package tqbls_pkg;

    localparam int unsigned OP_WIDTH     = 2;
    localparam int unsigned STATUS_WIDTH = 2;
    localparam int unsigned LIMIT_WIDTH  = 4;

    typedef logic [OP_WIDTH-1:0]     opcode_t;
    typedef logic [STATUS_WIDTH-1:0] status_t;
    typedef logic [LIMIT_WIDTH-1:0]  count_t;

    localparam opcode_t OP_GENERAL  = 2'd0;
    localparam opcode_t OP_PRIORITY = 2'd1;
    localparam opcode_t OP_SERVE    = 2'd2;

    localparam status_t ST_GENERAL  = 2'd0;
    localparam status_t ST_PRIORITY = 2'd1;
    localparam status_t ST_DROP     = 2'd2;

    localparam count_t BURST_RESET = 4'd3;
    localparam count_t RUN_MAX     = 4'd15;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_PRIORITY,
        SRC_GENERAL
    } source_t;

endpackage

### src/tqbls_if.sv
// Request and response channel interfaces
interface tqbls_req_if #(
    parameter int unsigned ID_WIDTH = 16
);
    import tqbls_pkg::*;

    logic                valid;
    logic                ready;
    opcode_t             opcode;
    logic [ID_WIDTH-1:0] customer_id;

    modport source (output valid, output opcode, output customer_id, input ready);
    modport sink   (input valid, input opcode, input customer_id, output ready);
endinterface

interface tqbls_rsp_if #(
    parameter int unsigned ID_WIDTH = 16
);
    import tqbls_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [ID_WIDTH-1:0] served_id;

    modport source (output valid, output status, output served_id, input ready);
    modport sink   (input valid, input status, input served_id, output ready);
endinterface

### src/tqbls_ram.sv
// Simple dual-port synchronous RAM holding one queue of customer ids
module tqbls_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### src/two_queue_burst_limited_scheduler_top.sv
// Two-queue burst-limited scheduler: pointer control, RAM read stage and output register
// Path: each result is held in the read stage, then in the output register.
// Throughput: one request per cycle; each does at most one RAM write or one RAM read.
// A stalled output holds the read stage, and the request side then waits.
// Reset: queues empty, run count zero, burst limit 3; RAM contents are not cleared.
module two_queue_burst_limited_scheduler_top #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned ID_WIDTH    = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  tqbls_pkg::count_t     cfg_wr_data,
    tqbls_req_if.sink             req,
    tqbls_rsp_if.source           rsp
);
    import tqbls_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

    count_t              limit_reg;
    count_t              run_reg, run_next;
    logic [AW-1:0]       p_head_reg, p_head_next, p_tail_reg, p_tail_next;
    logic [AW-1:0]       g_head_reg, g_head_next, g_tail_reg, g_tail_next;
    logic [FW-1:0]       p_fill_reg, p_fill_next, g_fill_reg, g_fill_next;

    logic                s1_valid_reg, s1_valid_next;
    source_t             s1_src_reg, s1_src_next;
    status_t             s1_status_reg, s1_status_next;
    logic [ID_WIDTH-1:0] s1_id_reg;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [ID_WIDTH-1:0] out_id_reg;

    logic                transfer, s1_go;
    logic                p_wr, g_wr, p_rd, g_rd;
    logic [ID_WIDTH-1:0] p_rdata, g_rdata;

    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_go;
    assign transfer  = req.valid && req.ready;

    tqbls_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_WIDTH), .AW(AW)) u_pri_ram (
        .clk     (clk),
        .wr_en   (p_wr),
        .wr_addr (p_tail_reg),
        .wr_data (req.customer_id),
        .rd_en   (p_rd),
        .rd_addr (p_head_reg),
        .rd_data (p_rdata)
    );

    tqbls_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ID_WIDTH), .AW(AW)) u_gen_ram (
        .clk     (clk),
        .wr_en   (g_wr),
        .wr_addr (g_tail_reg),
        .wr_data (req.customer_id),
        .rd_en   (g_rd),
        .rd_addr (g_head_reg),
        .rd_data (g_rdata)
    );

    always_comb
    begin
        p_wr           = 1'b0;
        g_wr           = 1'b0;
        p_rd           = 1'b0;
        g_rd           = 1'b0;
        run_next       = run_reg;
        p_head_next    = p_head_reg;
        p_tail_next    = p_tail_reg;
        p_fill_next    = p_fill_reg;
        g_head_next    = g_head_reg;
        g_tail_next    = g_tail_reg;
        g_fill_next    = g_fill_reg;
        s1_src_next    = SRC_NONE;
        s1_status_next = ST_DROP;
        s1_valid_next  = s1_go ? 1'b0 : s1_valid_reg;
        if (transfer)
        begin
            s1_valid_next = 1'b0;
            unique case (req.opcode)
                OP_GENERAL:
                begin
                    if (g_fill_reg == FULL_FILL)
                    begin
                        s1_valid_next = 1'b1;
                    end
                    else
                    begin
                        g_wr        = 1'b1;
                        g_tail_next = (g_tail_reg == LAST_SLOT) ? '0 : g_tail_reg + 1'b1;
                        g_fill_next = g_fill_reg + 1'b1;
                    end
                end
                OP_PRIORITY:
                begin
                    if (p_fill_reg == FULL_FILL)
                    begin
                        s1_valid_next = 1'b1;
                    end
                    else
                    begin
                        p_wr        = 1'b1;
                        p_tail_next = (p_tail_reg == LAST_SLOT) ? '0 : p_tail_reg + 1'b1;
                        p_fill_next = p_fill_reg + 1'b1;
                    end
                end
                OP_SERVE:
                begin
                    if (run_reg < limit_reg && p_fill_reg != '0)
                    begin
                        p_rd           = 1'b1;
                        p_head_next    = (p_head_reg == LAST_SLOT) ? '0 : p_head_reg + 1'b1;
                        p_fill_next    = p_fill_reg - 1'b1;
                        run_next       = (run_reg != RUN_MAX) ? run_reg + 1'b1 : run_reg;
                        s1_valid_next  = 1'b1;
                        s1_src_next    = SRC_PRIORITY;
                        s1_status_next = ST_PRIORITY;
                    end
                    else if (g_fill_reg != '0)
                    begin
                        g_rd           = 1'b1;
                        g_head_next    = (g_head_reg == LAST_SLOT) ? '0 : g_head_reg + 1'b1;
                        g_fill_next    = g_fill_reg - 1'b1;
                        run_next       = '0;
                        s1_valid_next  = 1'b1;
                        s1_src_next    = SRC_GENERAL;
                        s1_status_next = ST_GENERAL;
                    end
                end
                default:
                begin
                    s1_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= BURST_RESET;
            run_reg       <= '0;
            p_head_reg    <= '0;
            p_tail_reg    <= '0;
            p_fill_reg    <= '0;
            g_head_reg    <= '0;
            g_tail_reg    <= '0;
            g_fill_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            run_reg       <= run_next;
            p_head_reg    <= p_head_next;
            p_tail_reg    <= p_tail_next;
            p_fill_reg    <= p_fill_next;
            g_head_reg    <= g_head_next;
            g_tail_reg    <= g_tail_next;
            g_fill_reg    <= g_fill_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (transfer)
        begin
            s1_src_reg    <= s1_src_next;
            s1_status_reg <= s1_status_next;
            s1_id_reg     <= req.customer_id;
        end
        if (s1_go)
        begin
            out_status_reg <= s1_status_reg;
            case (s1_src_reg)
                SRC_PRIORITY: out_id_reg <= p_rdata;
                SRC_GENERAL:  out_id_reg <= g_rdata;
                default:      out_id_reg <= s1_id_reg;
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.served_id = out_id_reg;
endmodule

### tb/two_queue_burst_limited_scheduler_top_tb.sv
// Testbench for the two-queue burst-limited scheduler, checked against a local queue model
module two_queue_burst_limited_scheduler_top_tb;
    import tqbls_pkg::*;

    localparam int unsigned DEPTH = 64;
    localparam int unsigned ID_W  = 16;

    localparam int LINE_GENERAL  = 0;
    localparam int LINE_PRIORITY = 1;

    localparam logic [ID_W-1:0] ID_LOW  = '0;
    localparam logic [ID_W-1:0] ID_HIGH = '1;
    localparam opcode_t OP_UNUSED = 2'd3;

    typedef struct packed {
        opcode_t         op;
        logic [ID_W-1:0] id;
    } request_t;

    typedef struct packed {
        status_t         status;
        logic [ID_W-1:0] id;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en;
    count_t cfg_wr_data;

    tqbls_req_if #(.ID_WIDTH(ID_W)) req_ch ();
    tqbls_rsp_if #(.ID_WIDTH(ID_W)) rsp_ch ();

    two_queue_burst_limited_scheduler_top #(
        .QUEUE_DEPTH (DEPTH),
        .ID_WIDTH    (ID_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch.sink),
        .rsp         (rsp_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scheduler model
    logic [ID_W-1:0] line_store [2][DEPTH];
    int unsigned     line_head [2] = '{0, 0};
    int unsigned     line_fill [2] = '{0, 0};
    count_t          run_len = '0;
    count_t          limit_reg;

    request_t    request_backlog [$];
    outcome_t    awaited_outcomes [$];
    request_t    upcoming;
    outcome_t    observed;
    outcome_t    wanted;
    int unsigned requests_queued;
    int unsigned requests_taken  = 0;
    int unsigned results_checked = 0;
    int unsigned drops_seen      = 0;
    int unsigned priority_served = 0;
    int unsigned general_served  = 0;
    int unsigned mismatch_count  = 0;
    int unsigned burst_left      = 0;
    int unsigned gap_left        = 0;
    int unsigned stall_mode      = 0;
    int unsigned stall_age       = 0;
    int unsigned phase_no;
    logic        rsp_hold;

    int unsigned phase_limit  [6] = '{2, 0, 15, 1, 7, 11};
    int unsigned phase_arrive [6] = '{90, 45, 55, 90, 30, 50};
    int unsigned phase_prio   [6] = '{85, 50, 70, 20, 50, 50};
    int unsigned phase_count  [6] = '{130, 130, 130, 130, 130, 150};

    function automatic void schedule_request(opcode_t op, logic [ID_W-1:0] id);
        outcome_t    res;
        int          line;
        int unsigned slot;
        case (op)
            OP_GENERAL, OP_PRIORITY:
            begin
                line = (op == OP_PRIORITY) ? LINE_PRIORITY : LINE_GENERAL;
                if (line_fill[line] >= DEPTH)
                begin
                    res.status = ST_DROP;
                    res.id     = id;
                    awaited_outcomes.push_back(res);
                end
                else
                begin
                    slot = (line_head[line] + line_fill[line]) % DEPTH;
                    line_store[line][slot] = id;
                    line_fill[line]++;
                end
            end
            OP_SERVE:
            begin
                if (run_len < limit_reg && line_fill[LINE_PRIORITY] != 0)
                    line = LINE_PRIORITY;
                else if (line_fill[LINE_GENERAL] != 0)
                    line = LINE_GENERAL;
                else
                    return;
                res.status = (line == LINE_PRIORITY) ? ST_PRIORITY : ST_GENERAL;
                res.id     = line_store[line][line_head[line]];
                line_head[line] = (line_head[line] + 1) % DEPTH;
                line_fill[line]--;
                if (line == LINE_PRIORITY)
                begin
                    if (run_len != RUN_MAX)
                        run_len++;
                end
                else
                    run_len = '0;
                awaited_outcomes.push_back(res);
            end
            default:
                ;
        endcase
    endfunction

    function automatic void flag_mismatch(string detail);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH @%0t: %s", $realtime, detail);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.opcode      <= OP_GENERAL;
            req_ch.customer_id <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                schedule_request(req_ch.opcode, req_ch.customer_id);
                requests_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    upcoming = request_backlog.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.opcode      <= upcoming.op;
                    req_ch.customer_id <= upcoming.id;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                observed.status = rsp_ch.status;
                observed.id     = rsp_ch.served_id;
                if (awaited_outcomes.size() == 0)
                    flag_mismatch($sformatf("unexpected result status %0d id 0x%h",
                                            observed.status, observed.id));
                else
                begin
                    wanted = awaited_outcomes.pop_front();
                    results_checked++;
                    if (observed.status !== wanted.status)
                        flag_mismatch($sformatf("status expected %0d actual %0d",
                                                wanted.status, observed.status));
                    if (observed.id !== wanted.id)
                        flag_mismatch($sformatf("served_id expected 0x%h actual 0x%h",
                                                wanted.id, observed.id));
                    case (wanted.status)
                        ST_DROP:     drops_seen++;
                        ST_PRIORITY: priority_served++;
                        default:     general_served++;
                    endcase
                end
            end
            stall_age++;
            if (stall_age >= 50)
            begin
                stall_age  = 0;
                stall_mode = $urandom_range(0, 2);
            end
        end
        rsp_ch.ready <= !rsp_hold && (stall_mode == 0
                        || $urandom_range(0, 99) < ((stall_mode == 1) ? 70 : 25));
    end

    // long receiver hold-off while requests keep coming
    initial
    begin
        rsp_hold = 1'b0;
        wait (phase_no == 4);
        repeat (5) @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (80) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for results");
        $display("end of test: mismatches");
        $finish;
    end

    task automatic queue_request(opcode_t op, logic [ID_W-1:0] id);
        request_t item;
        item.op = op;
        item.id = id;
        request_backlog.push_back(item);
        requests_queued++;
    endtask

    task automatic wait_idle();
        while (requests_taken != requests_queued || awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(count_t value);
        wait_idle();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_reg = value;
    endtask

    task automatic queue_mixed(int unsigned count, int unsigned arrive_pct,
                               int unsigned prio_pct);
        int unsigned     pick;
        logic [ID_W-1:0] id;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0)
                id = $urandom_range(0, 1) ? ID_HIGH : ID_LOW;
            else
                id = ID_W'($urandom);
            if (pick < 2)
                queue_request(OP_UNUSED, id);
            else if (pick < arrive_pct)
                queue_request(($urandom_range(0, 99) < prio_pct) ? OP_PRIORITY : OP_GENERAL, id);
            else
                queue_request(OP_SERVE, id);
        end
    endtask

    initial
    begin
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        limit_reg          = BURST_RESET;
        requests_queued    = 0;
        phase_no           = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limit: empty serves, ignored opcode, id extremes, limit reached with general empty
        phase_no = 1;
        queue_request(OP_SERVE, ID_HIGH);
        queue_request(OP_UNUSED, ID_HIGH);
        queue_request(OP_GENERAL, ID_LOW);
        queue_request(OP_GENERAL, ID_HIGH);
        queue_request(OP_PRIORITY, ID_HIGH);
        queue_request(OP_PRIORITY, ID_LOW);
        queue_request(OP_PRIORITY, 16'h5A5A);
        queue_request(OP_PRIORITY, 16'hA5A5);
        repeat (6) queue_request(OP_SERVE, ID_LOW);
        for (int k = 1; k <= 4; k++)
            queue_request(OP_PRIORITY, ID_W'(k));
        repeat (4) queue_request(OP_SERVE, ID_LOW);

        // raise the limit, then lower it below the current run
        write_limit(count_t'(15));
        queue_request(OP_SERVE, ID_LOW);
        queue_request(OP_PRIORITY, 16'h8001);
        queue_request(OP_GENERAL, 16'h7FFE);
        write_limit(count_t'(1));
        queue_request(OP_SERVE, ID_LOW);

        phase_limit[4] = $urandom_range(1, 14);
        phase_limit[5] = $urandom_range(0, 15);
        for (int p = 0; p < 6; p++)
        begin
            write_limit(count_t'(phase_limit[p]));
            phase_no = p + 2;
            queue_mixed(phase_count[p], phase_arrive[p], phase_prio[p]);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (awaited_outcomes.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", awaited_outcomes.size()));

        $display("%0d requests under the reset limit and 8 written limits, %0d results checked",
                 requests_taken, results_checked);
        $display("priority serves %0d, general serves %0d, full-queue drops %0d",
                 priority_served, general_served, drops_seen);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
